>>> rtl/bba_pkg.sv
// Package for the buddy block allocator: sizes, index types and sequencer states.
// Used by the top level and the testbench; depends on nothing.
package bba_pkg;

   localparam int ARENA_ORDER = 20;
   localparam int MIN_ORDER   = 7;
   localparam int LO_ORDER    = (MIN_ORDER < ARENA_ORDER) ? MIN_ORDER : ARENA_ORDER;
   localparam int IDX_BITS    = ARENA_ORDER - LO_ORDER;
   localparam int LINK_DEPTH  = 1 << IDX_BITS;
   localparam int ORD_BITS    = 5;
   localparam int LINK_BITS   = IDX_BITS + 1;
   localparam int NUM_ORDERS  = ARENA_ORDER + 1;
   localparam int OVERHEAD    = 32;

   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [LINK_BITS-1:0] link_type;
   typedef logic [ORD_BITS-1:0]  ord_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_A_ROUND,
      ST_A_SCAN,
      ST_A_SPLIT_RD,
      ST_A_SPLIT_WAIT,
      ST_A_SPLIT_WB,
      ST_A_SPLIT_WP,
      ST_A_TAKE_RD,
      ST_A_TAKE_WAIT,
      ST_A_TAKE_END,
      ST_F_ROUND,
      ST_F_START,
      ST_F_WALK_RD,
      ST_F_WALK_WAIT,
      ST_F_WALK_CHK,
      ST_F_UNLINK,
      ST_F_PUSH,
      ST_RESP
   } state_type;

   // Memory write and read request from the sequencer to the link store.
   typedef struct packed {
      logic     wr_en;
      idx_type  wr_addr;
      link_type wr_data;
      idx_type  rd_addr;
   } link_req_type;

   // Smallest o such that 2^o >= n, for a 22-bit value.
   // A value above 2^21 needs order 22.
   function automatic logic [5:0] ceil_log2(input logic [21:0] n);
      logic [5:0] o;
      o = 6'd22;
      for (int i = 21; i >= 0; i--) begin
         if ((22'd1 << i) >= n) o = 6'(i);
      end
      return o;
   endfunction

endpackage

>>> rtl/bba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the free-link store.
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/buddy_block_allocator.sv
// Top level of the buddy block allocator: command port, sequencer, free-list heads.
// Depends on bba_pkg and bba_ram (the free-link store).
//
// Usage: drive req_* with start high while busy is low; that edge accepts the
// transaction. req_action 0 allocates req_request_size bytes (plus a 32-byte
// header, rounded up to a power of two); 1 frees req_block_address of size
// req_block_size. Exactly one result follows, shown for one cycle with
// rsp_valid high; the receiver cannot stall it and must take it then.
// busy stays high from acceptance through the result cycle, and the next
// transaction can be accepted at the end of the cycle after the result.
// Steps: an allocation rounds the size and scans the lists upward from that
// order; per order split it reads, waits, writes back and writes the pair, then
// reads, waits and takes the block. A free reads, waits and checks each list
// entry walked and unlinks per merge level, bounded by the list lengths. All cost
// is set by the single link memory port and the one head-table port used each step.
// Reset: the top-order list holds the whole arena as one block, the rest are
// empty. While reset is held the link entry of that first block is cleared so
// it ends its list; every other link entry is written before it is read, so
// the link memory needs no clearing pass.
module buddy_block_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [20:0] req_request_size,
   input  logic [19:0] req_block_address,
   input  logic [20:0] req_block_size,
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic [19:0] rsp_granted_address,
   output logic [4:0]  rsp_granted_order
);

   bba_pkg::state_type state_ff, state_in;
   bba_pkg::link_type  heads_ff [bba_pkg::NUM_ORDERS];
   bba_pkg::link_type  head_wdata;
   bba_pkg::ord_type   head_waddr;
   logic               head_we;

   logic [20:0]        size_ff;
   logic [19:0]        addr_ff;
   logic [20:0]        bsize_ff;
   bba_pkg::ord_type   o_ff, o_in;
   bba_pkg::ord_type   k_ff, k_in;
   bba_pkg::idx_type   idx_ff, idx_in;
   bba_pkg::idx_type   p_ff, p_in;
   bba_pkg::idx_type   prev_ff, prev_in;
   logic               have_prev_ff, have_prev_in;
   bba_pkg::link_type  cur_ff, cur_in;
   logic [bba_pkg::IDX_BITS:0] steps_ff, steps_in;
   logic               ok_ff, ok_in;

   bba_pkg::link_req_type lreq;
   bba_pkg::link_type     link_rd;

   logic [5:0]        round_o;
   bba_pkg::idx_type  buddy;
   bba_pkg::idx_type  bsplit;
   bba_pkg::idx_type  align_mask;
   bba_pkg::link_type head_k;

   bba_ram #(
      .WIDTH(bba_pkg::LINK_BITS),
      .DEPTH(bba_pkg::LINK_DEPTH)
   ) u_links (
      .clock   (clock),
      .wr_en   (lreq.wr_en),
      .wr_addr (lreq.wr_addr),
      .wr_data (lreq.wr_data),
      .rd_addr (lreq.rd_addr),
      .rd_data (link_rd)
   );

   // The one shared rounding unit: fed by request size or block size.
   always_comb begin
      if (state_ff == bba_pkg::ST_A_ROUND)
         round_o = bba_pkg::ceil_log2({1'b0, size_ff} + 22'(bba_pkg::OVERHEAD));
      else
         round_o = bba_pkg::ceil_log2({1'b0, bsize_ff});
   end

   assign head_k     = heads_ff[k_ff];
   assign buddy      = idx_ff ^ bba_pkg::idx_type'(1 << (o_ff - bba_pkg::ord_type'(bba_pkg::LO_ORDER)));
   assign bsplit     = p_ff ^ bba_pkg::idx_type'(1 << (k_ff - bba_pkg::ord_type'(bba_pkg::LO_ORDER + 1)));
   assign align_mask = ~bba_pkg::idx_type'((1 << (o_ff - bba_pkg::ord_type'(bba_pkg::LO_ORDER))) - 1);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bba_pkg::ST_IDLE:
            if (start) state_in = req_action ? bba_pkg::ST_F_ROUND : bba_pkg::ST_A_ROUND;
         bba_pkg::ST_A_ROUND:
            if (round_o > 6'(bba_pkg::ARENA_ORDER)) state_in = bba_pkg::ST_RESP;
            else state_in = bba_pkg::ST_A_SCAN;
         bba_pkg::ST_A_SCAN:
            if (head_k[bba_pkg::IDX_BITS])
               state_in = (k_ff > o_ff) ? bba_pkg::ST_A_SPLIT_RD : bba_pkg::ST_A_TAKE_RD;
            else if (k_ff == bba_pkg::ord_type'(bba_pkg::ARENA_ORDER))
               state_in = bba_pkg::ST_RESP;
         bba_pkg::ST_A_SPLIT_RD:   state_in = bba_pkg::ST_A_SPLIT_WAIT;
         bba_pkg::ST_A_SPLIT_WAIT: state_in = bba_pkg::ST_A_SPLIT_WB;
         bba_pkg::ST_A_SPLIT_WB:   state_in = bba_pkg::ST_A_SPLIT_WP;
         bba_pkg::ST_A_SPLIT_WP:
            state_in = (k_ff - 1'b1 > o_ff) ? bba_pkg::ST_A_SPLIT_RD : bba_pkg::ST_A_TAKE_RD;
         bba_pkg::ST_A_TAKE_RD:    state_in = bba_pkg::ST_A_TAKE_WAIT;
         bba_pkg::ST_A_TAKE_WAIT:  state_in = bba_pkg::ST_A_TAKE_END;
         bba_pkg::ST_A_TAKE_END:   state_in = bba_pkg::ST_RESP;
         bba_pkg::ST_F_ROUND:      state_in = bba_pkg::ST_F_START;
         bba_pkg::ST_F_START:
            if (o_ff >= bba_pkg::ord_type'(bba_pkg::ARENA_ORDER)) state_in = bba_pkg::ST_F_PUSH;
            else state_in = bba_pkg::ST_F_WALK_CHK;
         bba_pkg::ST_F_WALK_CHK:
            if (!cur_ff[bba_pkg::IDX_BITS] || steps_ff[bba_pkg::IDX_BITS])
               state_in = bba_pkg::ST_F_PUSH;
            else if (cur_ff[bba_pkg::IDX_BITS-1:0] == buddy)
               state_in = bba_pkg::ST_F_WALK_RD;
            else
               state_in = bba_pkg::ST_F_WALK_RD;
         bba_pkg::ST_F_WALK_RD:    state_in = bba_pkg::ST_F_WALK_WAIT;
         bba_pkg::ST_F_WALK_WAIT:
            state_in = (p_ff == buddy) ? bba_pkg::ST_F_UNLINK : bba_pkg::ST_F_WALK_CHK;
         bba_pkg::ST_F_UNLINK:     state_in = bba_pkg::ST_F_START;
         bba_pkg::ST_F_PUSH:       state_in = bba_pkg::ST_RESP;
         bba_pkg::ST_RESP:         state_in = bba_pkg::ST_IDLE;
         default:                  state_in = bba_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory control for each step.
   always_comb begin
      o_in         = o_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      p_in         = p_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      ok_in        = ok_ff;
      head_we      = 1'b0;
      head_waddr   = k_ff;
      head_wdata   = link_rd;
      lreq.wr_en   = 1'b0;
      lreq.wr_addr = p_ff;
      lreq.wr_data = link_rd;
      lreq.rd_addr = p_ff;
      unique case (state_ff)
         bba_pkg::ST_IDLE: begin
            ok_in = 1'b0;
            p_in  = '0;
            o_in  = '0;
         end
         bba_pkg::ST_A_ROUND: begin
            if (round_o < 6'(bba_pkg::LO_ORDER)) o_in = bba_pkg::ord_type'(bba_pkg::LO_ORDER);
            else o_in = round_o[bba_pkg::ORD_BITS-1:0];
            if (round_o < 6'(bba_pkg::LO_ORDER)) k_in = bba_pkg::ord_type'(bba_pkg::LO_ORDER);
            else k_in = round_o[bba_pkg::ORD_BITS-1:0];
            if (round_o > 6'(bba_pkg::ARENA_ORDER)) o_in = '0;
         end
         bba_pkg::ST_A_SCAN: begin
            if (!head_k[bba_pkg::IDX_BITS]) begin
               if (k_ff == bba_pkg::ord_type'(bba_pkg::ARENA_ORDER)) o_in = '0;
               else k_in = k_ff + 1'b1;
            end
         end
         bba_pkg::ST_A_SPLIT_RD, bba_pkg::ST_A_TAKE_RD: begin
            p_in         = head_k[bba_pkg::IDX_BITS-1:0];
            lreq.rd_addr = head_k[bba_pkg::IDX_BITS-1:0];
         end
         bba_pkg::ST_A_SPLIT_WAIT, bba_pkg::ST_A_TAKE_WAIT: begin
         end
         bba_pkg::ST_A_SPLIT_WB: begin
            // Pop the block, link its upper half ahead of the lower list's head.
            head_we      = 1'b1;
            head_waddr   = k_ff;
            head_wdata   = link_rd;
            lreq.wr_en   = 1'b1;
            lreq.wr_addr = bsplit;
            lreq.wr_data = heads_ff[k_ff - 1'b1];
         end
         bba_pkg::ST_A_SPLIT_WP: begin
            lreq.wr_en   = 1'b1;
            lreq.wr_addr = p_ff;
            lreq.wr_data = {1'b1, bsplit};
            head_we      = 1'b1;
            head_waddr   = k_ff - 1'b1;
            head_wdata   = {1'b1, p_ff};
            k_in         = k_ff - 1'b1;
         end
         bba_pkg::ST_A_TAKE_END: begin
            head_we    = 1'b1;
            head_waddr = o_ff;
            head_wdata = link_rd;
            ok_in      = 1'b1;
         end
         bba_pkg::ST_F_ROUND: begin
            ok_in = 1'b1;
            if (round_o < 6'(bba_pkg::LO_ORDER)) o_in = bba_pkg::ord_type'(bba_pkg::LO_ORDER);
            else if (round_o > 6'(bba_pkg::ARENA_ORDER))
               o_in = bba_pkg::ord_type'(bba_pkg::ARENA_ORDER);
            else o_in = round_o[bba_pkg::ORD_BITS-1:0];
            idx_in = addr_ff[19 -: bba_pkg::IDX_BITS];
         end
         bba_pkg::ST_F_START: begin
            idx_in       = idx_ff & align_mask;
            k_in         = o_ff;
            cur_in       = heads_ff[o_ff];
            have_prev_in = 1'b0;
            steps_in     = '0;
         end
         bba_pkg::ST_F_WALK_CHK: begin
            lreq.rd_addr = cur_ff[bba_pkg::IDX_BITS-1:0];
            p_in         = cur_ff[bba_pkg::IDX_BITS-1:0];
         end
         bba_pkg::ST_F_WALK_RD: begin
         end
         bba_pkg::ST_F_WALK_WAIT: begin
            if (p_ff != buddy) begin
               prev_in      = p_ff;
               have_prev_in = 1'b1;
               cur_in       = link_rd;
               steps_in     = steps_ff + 1'b1;
            end
         end
         bba_pkg::ST_F_UNLINK: begin
            if (have_prev_ff) begin
               lreq.wr_en   = 1'b1;
               lreq.wr_addr = prev_ff;
               lreq.wr_data = link_rd;
            end else begin
               head_we    = 1'b1;
               head_waddr = o_ff;
               head_wdata = link_rd;
            end
            if (buddy < idx_ff) idx_in = buddy;
            o_in = o_ff + 1'b1;
         end
         bba_pkg::ST_F_PUSH: begin
            lreq.wr_en   = 1'b1;
            lreq.wr_addr = idx_ff;
            lreq.wr_data = heads_ff[o_ff];
            head_we      = 1'b1;
            head_waddr   = o_ff;
            head_wdata   = {1'b1, idx_ff};
            o_in         = '0;
            p_in         = '0;
         end
         bba_pkg::ST_RESP: begin
         end
         default: begin
         end
      endcase
      // While reset is held, clear the link entry of the arena's first block.
      if (reset) begin
         lreq.wr_en   = 1'b1;
         lreq.wr_addr = '0;
         lreq.wr_data = '0;
      end
   end

   // Control registers and the head table.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::ST_IDLE;
         for (int i = 0; i < bba_pkg::NUM_ORDERS; i++)
            heads_ff[i] <= (i == bba_pkg::ARENA_ORDER) ? {1'b1, bba_pkg::idx_type'(0)} : '0;
      end else begin
         state_ff <= state_in;
         if (head_we) heads_ff[head_waddr] <= head_wdata;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (state_ff == bba_pkg::ST_IDLE && start) begin
         size_ff  <= req_request_size;
         addr_ff  <= req_block_address;
         bsize_ff <= req_block_size;
      end
      o_ff         <= o_in;
      k_ff         <= k_in;
      idx_ff       <= idx_in;
      p_ff         <= p_in;
      prev_ff      <= prev_in;
      have_prev_ff <= have_prev_in;
      cur_ff       <= cur_in;
      steps_ff     <= steps_in;
      ok_ff        <= ok_in;
   end

   // Result outputs.
   always_comb begin
      busy      = (state_ff != bba_pkg::ST_IDLE);
      rsp_valid = (state_ff == bba_pkg::ST_RESP);
      rsp_ok    = ok_ff;
      if (ok_ff && o_ff != '0) begin
         rsp_granted_address = 20'({p_ff, bba_pkg::LO_ORDER'(0)});
         rsp_granted_order   = o_ff;
      end else begin
         rsp_granted_address = '0;
         rsp_granted_order   = '0;
      end
   end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for buddy_block_allocator: scoreboard class with a buddy predictor,
// directed and random allocate/free transactions. Depends on bba_pkg and the RTL top level.
`timescale 1ns / 100ps

module testbench;
   import bba_pkg::*;

   localparam int ACT_ALLOC = 0;
   localparam int ACT_FREE  = 1;

   typedef struct {
      logic        ok;
      logic [19:0] granted_address;
      logic [4:0]  granted_order;
   } grant_type;

   typedef struct {
      logic [19:0] addr;
      int          ord;
   } held_type;

   // Scoreboard: tracks the free lists and checks each result against the oldest expectation.
   class allocator_scoreboard;
      link_type  list_heads[NUM_ORDERS];
      link_type  next_links[LINK_DEPTH];
      grant_type grants_due[$];
      int        mismatches;

      function new();
         mismatches = 0;
         foreach (next_links[i]) next_links[i] = '0;
         foreach (list_heads[i]) list_heads[i] = '0;
         list_heads[ARENA_ORDER] = {1'b1, idx_type'(0)};
      endfunction

      function int order_for(longint unsigned n);
         int o;
         o = 0;
         while (o < 63 && (64'd1 << o) < n) o++;
         return o;
      endfunction

      function grant_type grant_block(longint unsigned size);
         grant_type g;
         int        o;
         int        k;
         idx_type   p;
         idx_type   b;
         g = '{1'b0, 20'd0, 5'd0};
         o = order_for(size + OVERHEAD);
         if (o < LO_ORDER) o = LO_ORDER;
         if (o > ARENA_ORDER) return g;
         k = o;
         while (k <= ARENA_ORDER && !list_heads[k][IDX_BITS]) k++;
         if (k > ARENA_ORDER) return g;
         // Split down to the wanted order, pushing both halves each level.
         while (k > o) begin
            p = list_heads[k][IDX_BITS-1:0];
            list_heads[k] = next_links[p];
            b = p ^ idx_type'(1 << (k - 1 - LO_ORDER));
            next_links[b] = list_heads[k-1];
            next_links[p] = {1'b1, b};
            list_heads[k-1] = {1'b1, p};
            k--;
         end
         p = list_heads[o][IDX_BITS-1:0];
         list_heads[o] = next_links[p];
         g.ok = 1'b1;
         g.granted_address = 20'(p) << LO_ORDER;
         g.granted_order = 5'(o);
         return g;
      endfunction

      function void release_block(logic [19:0] addr, logic [20:0] bsize);
         int       o;
         int       steps;
         idx_type  idx;
         idx_type  buddy;
         idx_type  c;
         idx_type  prev;
         link_type cur;
         bit       have_prev;
         bit       found;
         o = order_for(bsize);
         if (o < LO_ORDER) o = LO_ORDER;
         if (o > ARENA_ORDER) o = ARENA_ORDER;
         idx = idx_type'(addr >> LO_ORDER);
         idx &= ~idx_type'((1 << (o - LO_ORDER)) - 1);
         // Merge with the buddy for as long as it is found free.
         while (o < ARENA_ORDER) begin
            buddy = idx ^ idx_type'(1 << (o - LO_ORDER));
            cur = list_heads[o];
            have_prev = 0;
            found = 0;
            prev = '0;
            steps = 0;
            while (cur[IDX_BITS] && steps < LINK_DEPTH) begin
               c = cur[IDX_BITS-1:0];
               if (c == buddy) begin
                  if (have_prev) next_links[prev] = next_links[c];
                  else list_heads[o] = next_links[c];
                  found = 1;
                  break;
               end
               prev = c;
               have_prev = 1;
               cur = next_links[c];
               steps++;
            end
            if (!found) break;
            if (buddy < idx) idx = buddy;
            o++;
         end
         next_links[idx] = list_heads[o];
         list_heads[o] = {1'b1, idx};
      endfunction

      // Notes an accepted transaction and returns the result it must produce.
      function grant_type note_request(bit action, logic [20:0] size, logic [19:0] addr,
                                       logic [20:0] bsize);
         grant_type g;
         if (action == ACT_ALLOC) begin
            g = grant_block(size);
         end else begin
            release_block(addr, bsize);
            g = '{1'b1, 20'd0, 5'd0};
         end
         grants_due.push_back(g);
         return g;
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("%0t: %s got %0d expected %0d", $time, what, got, want);
         mismatches++;
      endtask

      task check_result(logic ok, logic [19:0] addr, logic [4:0] ord);
         grant_type g;
         if (grants_due.size() == 0) begin
            report_mismatch("unexpected result, ok", ok, 0);
         end else begin
            g = grants_due.pop_front();
            if (ok !== g.ok) report_mismatch("ok", ok, g.ok);
            if (addr !== g.granted_address)
               report_mismatch("granted_address", addr, g.granted_address);
            if (ord !== g.granted_order) report_mismatch("granted_order", ord, g.granted_order);
         end
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_action = 0;
   logic [20:0] req_request_size = '0;
   logic [19:0] req_block_address = '0;
   logic [20:0] req_block_size = '0;
   logic        rsp_valid;
   logic        rsp_ok;
   logic [19:0] rsp_granted_address;
   logic [4:0]  rsp_granted_order;

   allocator_scoreboard sb = new();
   held_type held_blocks[$];
   int burst_left = 0;
   int alloc_count = 0;
   int free_count = 0;
   int fail_count = 0;

   always #6 clock = ~clock;

   buddy_block_allocator i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_request_size(req_request_size),
      .req_block_address(req_block_address), .req_block_size(req_block_size),
      .rsp_valid(rsp_valid), .rsp_ok(rsp_ok),
      .rsp_granted_address(rsp_granted_address), .rsp_granted_order(rsp_granted_order)
   );

   // Results cannot be held off, so every strobed cycle is checked.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_ok, rsp_granted_address, rsp_granted_order);
   end

   // Sends one transaction, sometimes inserting sender gaps between bursts.
   task send_item(bit action, logic [20:0] size, logic [19:0] addr, logic [20:0] bsize);
      grant_type g;
      int        gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_action <= action;
      req_request_size <= size;
      req_block_address <= addr;
      req_block_size <= bsize;
      start <= 1'b1;
      forever begin
         @(posedge clock);
         if (start && !busy) break;
      end
      g = sb.note_request(action, size, addr, bsize);
      if (action == ACT_ALLOC) begin
         alloc_count++;
         if (g.ok) held_blocks.push_back('{g.granted_address, g.granted_order});
         else fail_count++;
      end else begin
         free_count++;
      end
   endtask

   // Frees a held block, sometimes with stray low address bits or a non power-of-two size.
   task free_held(int pos, bit odd);
      held_type    h;
      logic [19:0] addr;
      logic [20:0] bsize;
      h = held_blocks[pos];
      held_blocks.delete(pos);
      addr = h.addr;
      bsize = 21'(1) << h.ord;
      if (odd) begin
         addr = h.addr | 20'($urandom_range(0, (1 << h.ord) - 1));
         if (h.ord > LO_ORDER) bsize = 21'($urandom_range((1 << (h.ord - 1)) + 1, 1 << h.ord));
         else bsize = 21'($urandom_range(0, 1 << LO_ORDER));
      end
      send_item(ACT_FREE, 21'd0, addr, bsize);
   endtask

   initial begin
      int          r;
      logic [20:0] size;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: whole arena, tiny requests, rounding edges, odd frees, failures.
      send_item(ACT_ALLOC, 21'd1048544, 20'd0, 21'd0);
      send_item(ACT_ALLOC, 21'd0, 20'd0, 21'd0);
      free_held(0, 0);
      send_item(ACT_ALLOC, 21'd0, 20'd0, 21'd0);
      send_item(ACT_ALLOC, 21'd96, 20'd0, 21'd0);
      send_item(ACT_ALLOC, 21'd97, 20'd0, 21'd0);
      send_item(ACT_ALLOC, 21'd1000, 20'd0, 21'd0);
      send_item(ACT_ALLOC, 21'd1048576, 20'd0, 21'd0);
      send_item(ACT_ALLOC, 21'd524256, 20'd0, 21'd0);
      send_item(ACT_ALLOC, 21'd524256, 20'd0, 21'd0);
      send_item(ACT_FREE, 21'd0, held_blocks[0].addr | 20'h7F, 21'd0);
      held_blocks.delete(0);
      free_held(0, 1);
      free_held(0, 1);
      free_held(0, 0);
      send_item(ACT_ALLOC, 21'd1048544, 20'd0, 21'd0);
      send_item(ACT_FREE, 21'd0, 20'hFFFFF, 21'h1FFFFF);
      send_item(ACT_ALLOC, 21'd1048544, 20'd0, 21'd0);
      send_item(ACT_ALLOC, 21'd33, 20'd0, 21'd0);
      while (held_blocks.size() > 0) free_held(0, 0);

      // Random: mostly well-formed alloc/free traffic with small sizes.
      repeat (400) begin
         r = $urandom_range(0, 99);
         if (held_blocks.size() == 0 || (held_blocks.size() < 40 && r < 58)) begin
            r = $urandom_range(0, 99);
            if (r < 85) size = 21'($urandom_range(0, 1 << $urandom_range(5, 13)));
            else if (r < 97) size = 21'($urandom_range(0, 1 << 18));
            else size = 21'($urandom_range(0, 1048576));
            send_item(ACT_ALLOC, size, 20'd0, 21'd0);
         end else begin
            free_held($urandom_range(0, held_blocks.size() - 1), $urandom_range(0, 4) == 0);
         end
      end

      // Noise at the end: frees of arbitrary blocks, random allocations and a double free.
      if (held_blocks.size() > 0) begin
         send_item(ACT_FREE, 21'd0, held_blocks[0].addr, 21'(1) << held_blocks[0].ord);
         send_item(ACT_FREE, 21'd0, held_blocks[0].addr, 21'(1) << held_blocks[0].ord);
      end
      repeat (8) begin
         send_item(ACT_FREE, 21'd0, 20'($urandom_range(0, 1048575)),
                   21'($urandom_range(0, 1048576)));
         send_item(ACT_ALLOC, 21'($urandom_range(0, 4096)), 20'd0, 21'd0);
      end

      start <= 1'b0;
      while (sb.grants_due.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Covered %0d allocations (%0d refused) and %0d frees, including merges,",
               alloc_count, fail_count, free_count);
      $display("odd free sizes and addresses, whole-arena blocks and a double free.");
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog for a hung sequencer; long list walks after bad frees are allowed for.
   initial begin
      #3s;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
